FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_AT_CLK(name, clock, reset, prop, msg) \
  name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(name, clock, reset, cond, msg) \
  name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`else

`define ASSERT_AT_CLK(name, clock, reset, prop, msg)
`define ASSERT_NEVER(name, clock, reset, cond, msg)

`endif

`endif

FILE: rtl/sss_pkg.sv
package sss_pkg;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_REFUSED = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_t;

  typedef struct packed {
    logic               advance;
    logic               commit;
    logic               ins_wr;
    logic               rem_wr;
    logic               desc;
    logic signed [31:0] x;
  } cell_ctl_t;

endpackage

FILE: rtl/sss_cell.sv
module sss_cell (
  input  logic                clk,
  input  logic                rst,
  input  sss_pkg::cell_ctl_t  ctl,
  input  logic                pass_in,
  input  logic signed [31:0]  left_value,
  input  logic                left_occ,
  input  logic signed [31:0]  right_value,
  input  logic                right_occ,
  output logic signed [31:0]  cell_value,
  output logic                occ,
  output logic                pass_out,
  output logic                stop,
  output logic                hit
);
  import sss_pkg::*;

  logic probe;
  logic passed;
  logic lies_before;

  assign lies_before = ctl.desc ? (cell_value > ctl.x) : (cell_value < ctl.x);
  assign pass_out    = probe & occ & lies_before;
  assign stop        = probe & ~pass_out;
  assign hit         = stop & occ & (cell_value == ctl.x);

  always_ff @(posedge clk) begin
    if (rst) begin
      probe  <= 1'b0;
      passed <= 1'b0;
    end else if (ctl.commit) begin
      probe  <= 1'b0;
      passed <= 1'b0;
    end else if (ctl.advance) begin
      probe  <= pass_in;
      passed <= passed | pass_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctl.ins_wr && !passed) begin
      occ <= probe ? 1'b1 : left_occ;
    end else if (ctl.rem_wr && !passed) begin
      occ <= right_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins_wr && !passed) begin
      cell_value <= probe ? ctl.x : left_value;
    end else if (ctl.rem_wr && !passed) begin
      cell_value <= right_value;
    end
  end

endmodule

FILE: rtl/sorted_set_insert_remove.sv
// Channel  | Signals                         | Direction
// ---------+---------------------------------+----------
// request  | in_valid in_ready req_type value | in
// result   | out_valid out_ready status       | out
//          |   entry_count                    |
// config   | cfg_valid cfg_ready cfg_data     | in
//
// A request walks the cell chain one cell per cycle from the front until it
// stops at cell pos; the cells and the result register update when the
// search has stopped and the result register is free, and in_ready rises
// the cycle after.
// One request is in progress at a time; in_ready is high only when idle.
// A stalled result holds the search at its stop cell until the transfer.
// Reset is synchronous and empties the set; descending resets to 1.
`include "assert_macros.svh"

module sorted_set_insert_remove #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [5:0]         entry_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import sss_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  state_t             state;
  state_t             state_next;
  logic               descending;
  logic               req_remove;
  logic signed [31:0] x_reg;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  cell_ctl_t          ctl;
  logic               advance;
  logic               commit;
  logic               ins_wr;
  logic               rem_wr;

  logic                  start;
  logic                  stop_any;
  logic                  hit_any;
  logic                  full;
  logic                  out_free;
  status_t               status_next;
  logic signed [31:0]    value_w [CAPACITY];
  logic [CAPACITY-1:0]   occ_w;
  logic [CAPACITY:0]     pass_w;
  logic [CAPACITY-1:0]   stop_w;
  logic [CAPACITY-1:0]   hit_w;

  assign cfg_ready = 1'b1;
  assign start     = in_valid & in_ready;
  assign out_free  = ~out_valid | out_ready;
  assign stop_any  = (|stop_w) | pass_w[CAPACITY];
  assign hit_any   = |hit_w;
  assign full      = (count == CW'(CAPACITY));
  assign pass_w[0] = start;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      descending <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_remove <= (req_type == REQ_REMOVE);
      x_reg      <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (stop_any && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    advance  = 1'b0;
    commit   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        advance  = start;
      end
      ST_SEARCH: begin
        advance = ~stop_any;
        commit  = stop_any & out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (req_remove) begin
      status_next = hit_any ? STATUS_DONE : STATUS_REFUSED;
    end else if (hit_any) begin
      status_next = STATUS_REFUSED;
    end else if (full) begin
      status_next = STATUS_FULL;
    end else begin
      status_next = STATUS_DONE;
    end
  end

  assign ins_wr = commit & ~req_remove & ~hit_any & ~full;
  assign rem_wr = commit & req_remove & hit_any;
  assign ctl    = '{advance: advance, commit: commit, ins_wr: ins_wr,
                    rem_wr: rem_wr, desc: descending, x: x_reg};

  always_comb begin
    count_next = count;
    if (ins_wr) begin
      count_next = count + CW'(1);
    end else if (rem_wr) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status      <= status_next;
      entry_count <= 6'(count_next);
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left_value;
      logic               left_occ;
      logic signed [31:0] right_value;
      logic               right_occ;

      if (i == 0) begin : g_first
        assign left_value = '0;
        assign left_occ   = 1'b0;
      end else begin : g_mid_left
        assign left_value = value_w[i-1];
        assign left_occ   = occ_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign right_value = '0;
        assign right_occ   = 1'b0;
      end else begin : g_mid_right
        assign right_value = value_w[i+1];
        assign right_occ   = occ_w[i+1];
      end

      sss_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .pass_in     (pass_w[i]),
        .left_value  (left_value),
        .left_occ    (left_occ),
        .right_value (right_value),
        .right_occ   (right_occ),
        .cell_value  (value_w[i]),
        .occ         (occ_w[i]),
        .pass_out    (pass_w[i+1]),
        .stop        (stop_w[i]),
        .hit         (hit_w[i])
      );
    end
  endgenerate

  `ASSERT_AT_CLK(a_single_stop, clk, rst, $onehot0(stop_w), "more than one cell stopped")
  `ASSERT_NEVER(a_count_range, clk, rst, count > CW'(CAPACITY), "entry count above capacity")
  `ASSERT_NEVER(a_idle_quiet, clk, rst, (state == ST_IDLE) && stop_any, "search active while idle")
  `ASSERT_AT_CLK(a_full_status, clk, rst, out_valid && status == STATUS_FULL |-> full, "full with room")

endmodule

FILE: tb/testbench.sv
module testbench;
  import sss_pkg::*;

  localparam int CAPACITY     = 32;
  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 134;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 5000;
  localparam bit ORDER_PLAN [N_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

  typedef struct {
    req_t               op;
    logic signed [31:0] val;
  } request_t;

  typedef struct {
    status_t    status;
    logic [5:0] entry_count;
  } result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               req_type = 1'b0;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [5:0]         entry_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;

  request_t           pending_requests[$];
  result_t            expected_results[$];

  logic signed [31:0] set_cells[CAPACITY];
  int                 set_count = 0;
  logic               set_descending = 1'b1;

  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  bit hold_arm = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  int idle_cycles = 0;

  int err_count = 0;
  int total_items = 0;
  int n_done = 0;
  int n_refused = 0;
  int n_full = 0;
  int order_writes = 0;

  sorted_set_insert_remove #(.CAPACITY(CAPACITY)) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .entry_count (entry_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Walk the set in the current order, then insert or take out at the stop cell.
  function automatic void apply_request(req_t op, logic signed [31:0] v);
    int      pos;
    logic    hit;
    result_t res;
    pos = 0;
    while (pos < set_count &&
           (set_descending ? (set_cells[pos] > v) : (set_cells[pos] < v)))
      pos++;
    hit = (pos < set_count) && (set_cells[pos] == v);
    if (op == REQ_INSERT) begin
      if (hit) begin
        res.status = STATUS_REFUSED;
      end else if (set_count >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        for (int k = set_count; k > pos; k--) set_cells[k] = set_cells[k - 1];
        set_cells[pos] = v;
        set_count++;
        res.status = STATUS_DONE;
      end
    end else begin
      if (!hit) begin
        res.status = STATUS_REFUSED;
      end else begin
        for (int k = pos; k + 1 < set_count; k++) set_cells[k] = set_cells[k + 1];
        set_count--;
        res.status = STATUS_DONE;
      end
    end
    res.entry_count = set_count[5:0];
    case (res.status)
      STATUS_DONE:    n_done++;
      STATUS_REFUSED: n_refused++;
      default:        n_full++;
    endcase
    expected_results.push_back(res);
  endfunction

  function automatic logic signed [31:0] pool_value();
    logic signed [31:0] base;
    case ($urandom_range(2))
      0:       base = -32'sd20;
      1:       base = 32'sh7fffffd8;
      default: base = 32'sh80000000;
    endcase
    return base + $urandom_range(39);
  endfunction

  function automatic void shuffle_values(ref logic signed [31:0] vals[$]);
    int                 k;
    logic signed [31:0] tmp;
    for (int j = vals.size() - 1; j > 0; j--) begin
      k = $urandom_range(j);
      tmp = vals[j];
      vals[j] = vals[k];
      vals[k] = tmp;
    end
  endfunction

  task automatic queue_request(req_t op, logic signed [31:0] v);
    request_t r;
    r.op = op;
    r.val = v;
    pending_requests.push_back(r);
    total_items++;
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
  endtask

  // Request driver: advance on transfer, hold otherwise.
  always @(posedge clk) begin
    request_t nxt;
    logic     offer;
    if (rst) begin
      in_valid <= 1'b0;
      req_type <= REQ_INSERT;
      value    <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) apply_request(req_t'(req_type), value);
      offer = (pending_requests.size() != 0) && ($urandom_range(99) >= send_idle_pct);
      if (offer) begin
        nxt = pending_requests.pop_front();
        req_type <= nxt.op;
        value    <= nxt.val;
      end
      in_valid <= offer;
    end
  end

  // Result side ready, with one long hold-off when armed.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_cnt != 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_arm && !hold_done) begin
      out_ready <= 1'b0;
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d entry_count %0d", status, entry_count);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          err_count++;
        end
        if (entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
    begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int                 phase_start;
    int                 kind;
    int                 n;
    int                 stride;
    logic signed [31:0] base;
    logic signed [31:0] fill_vals[$];
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    queue_request(REQ_REMOVE, 32'sd0);
    queue_request(REQ_INSERT, 32'sd0);
    queue_request(REQ_INSERT, 32'sd0);
    queue_request(REQ_INSERT, 32'sh7fffffff);
    queue_request(REQ_INSERT, 32'sh80000000);
    queue_request(REQ_INSERT, -32'sd1);
    queue_request(REQ_INSERT, 32'sd1);
    queue_request(REQ_INSERT, 32'sh80000000);
    queue_request(REQ_REMOVE, -32'sd1);
    queue_request(REQ_REMOVE, -32'sd1);
    queue_request(REQ_INSERT, 32'sh55555555);
    queue_request(REQ_INSERT, 32'shaaaaaaaa);
    queue_request(REQ_REMOVE, 32'sh7fffffff);
    queue_request(REQ_REMOVE, 32'sh80000000);
    queue_request(REQ_REMOVE, 32'sh7ffffffe);
    queue_request(REQ_INSERT, 32'sh7fffffff);
    queue_request(REQ_REMOVE, 32'sd0);
    queue_request(REQ_INSERT, 32'sh80000001);
    wait_idle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      @(posedge clk);
      cfg_data  <= ORDER_PLAN[ph];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      set_descending = ORDER_PLAN[ph];
      order_writes++;

      send_idle_pct <= (ph % 4 == 1) ? 57 : (ph % 4 == 3) ? 9 : 0;
      rcv_stall_pct <= (ph % 4 == 2) ? 57 : (ph % 4 == 3) ? 9 : 0;
      hold_arm      <= (ph == 4);

      phase_start = total_items;
      while (total_items - phase_start < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 30) begin
          // fill past capacity with distinct values, then maybe drain them
          n = $urandom_range(CAPACITY + 6, CAPACITY + 2);
          stride = $urandom_range(1000, 1);
          base = $urandom_range(1) ? $urandom : pool_value();
          fill_vals.delete();
          for (int j = 0; j < n; j++) fill_vals.push_back(base + j * stride);
          shuffle_values(fill_vals);
          foreach (fill_vals[j]) queue_request(REQ_INSERT, fill_vals[j]);
          if ($urandom_range(1)) begin
            shuffle_values(fill_vals);
            foreach (fill_vals[j]) queue_request(REQ_REMOVE, fill_vals[j]);
          end
        end else if (kind < 80) begin
          for (int j = 0; j < 20; j++)
            queue_request(($urandom_range(99) < 55) ? REQ_INSERT : REQ_REMOVE,
                          ($urandom_range(9) == 0) ? $urandom : pool_value());
        end else begin
          for (int j = 0; j < 10; j++)
            queue_request(req_t'($urandom_range(1)), $urandom);
        end
      end
      wait_idle();
    end

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      err_count++;
    end
    $display("Covered %0d requests in %0d phases with %0d order writes", total_items,
             N_PHASES + 1, order_writes);
    $display("Outcomes: %0d done, %0d refused, %0d refused as full", n_done, n_refused, n_full);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
